// File: src/cdq_pkg.sv
// Package for the circular deque: operation and status codes, controller states
// and the record of a transaction in flight. Has no dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] popped;
      logic        pop_from_rd;
      logic        head_from_rd;
   } pend_type;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

endpackage

// File: src/circular_deque.sv
// Top level of the circular deque: ring memory, index and count registers,
// controller and result register. Depends on cdq_pkg.
`timescale 1ns / 1ps

// Each request transaction is one push or pop on a deque of DEPTH signed words.
// The memory is written or read in the cycle a request is accepted, and the
// result is formed in the next cycle from the registered read data of the
// single-port ring memory. The busy state is held for as long as the output
// register still holds a result that has not been taken. A new request is
// taken as soon as the controller is idle again, even while the last result
// still waits in the output register.
// Pushes into a full deque and pops from an empty one are refused with a
// status code and leave the state unchanged.
module circular_deque #(
   parameter int DEPTH = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: func[1:0], push_value[33:2], zero pad[39:34].
   input  logic [cdq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: status[1:0], popped_value[33:2], count[37:34],
   // head_value[69:38], zero pad[71:70].
   output logic [cdq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [31:0] mem [DEPTH];

   cdq_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [31:0]        head_val_ff, head_val_in;
   cdq_pkg::pend_type  pend_ff, pend_in;
   logic [31:0]        rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_ok, load_out;
   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [IDX_W-1:0]   head_next, head_prev, tail_next, tail_prev;
   cdq_pkg::op_type    op;
   logic [31:0]        value;
   logic [31:0]        head_now, head_rep, popped_rep;
   logic [CNT_W+3:0]   cnt_ext;

   assign op    = cdq_pkg::op_type'(req_tdata[1:0]);
   assign value = req_tdata[33:2];
   assign req_ok = req_tvalid && req_tready;

   assign head_next = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
   assign head_prev = (head_ff == '0) ? IDX_LAST : head_ff - IDX_W'(1);
   assign tail_next = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);
   assign tail_prev = (tail_ff == '0) ? IDX_LAST : tail_ff - IDX_W'(1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::S_IDLE: begin
            if (req_ok) begin
               state_in = cdq_pkg::S_BUSY;
            end
         end
         cdq_pkg::S_BUSY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = cdq_pkg::S_IDLE;
            end
         end
         default: state_in = cdq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         cdq_pkg::S_IDLE: req_tready = 1'b1;
         cdq_pkg::S_BUSY: load_out = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            load_out   = 1'b0;
         end
      endcase
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      head_val_in = head_val_ff;
      pend_in     = pend_ff;
      wr_en       = 1'b0;
      wr_addr     = head_prev;
      rd_en       = 1'b0;
      rd_addr     = head_next;
      if (req_ok) begin
         pend_in.status       = cdq_pkg::ST_DONE;
         pend_in.popped       = '0;
         pend_in.pop_from_rd  = 1'b0;
         pend_in.head_from_rd = 1'b0;
         case (op)
            cdq_pkg::OP_PUSH_FRONT: begin
               if (fill_ff == CNT_FULL) begin
                  pend_in.status = cdq_pkg::ST_FULL;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = head_prev;
                  head_in     = head_prev;
                  fill_in     = fill_ff + CNT_W'(1);
                  head_val_in = value;
               end
            end
            cdq_pkg::OP_PUSH_BACK: begin
               if (fill_ff == CNT_FULL) begin
                  pend_in.status = cdq_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = tail_ff;
                  tail_in = tail_next;
                  fill_in = fill_ff + CNT_W'(1);
                  if (fill_ff == '0) begin
                     head_val_in = value;
                  end
               end
            end
            cdq_pkg::OP_POP_FRONT: begin
               if (fill_ff == '0) begin
                  pend_in.status = cdq_pkg::ST_EMPTY;
               end else begin
                  pend_in.popped       = head_val_ff;
                  pend_in.head_from_rd = (fill_ff != CNT_W'(1));
                  rd_en   = 1'b1;
                  rd_addr = head_next;
                  head_in = head_next;
                  fill_in = fill_ff - CNT_W'(1);
               end
            end
            cdq_pkg::OP_POP_BACK: begin
               if (fill_ff == '0) begin
                  pend_in.status = cdq_pkg::ST_EMPTY;
               end else begin
                  pend_in.pop_from_rd = 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = tail_prev;
                  tail_in = tail_prev;
                  fill_in = fill_ff - CNT_W'(1);
               end
            end
            default: pend_in.status = cdq_pkg::ST_DONE;
         endcase
      end else if (load_out && pend_ff.head_from_rd) begin
         head_val_in = rd_data_ff;
      end
   end

   always_comb begin
      head_now   = pend_ff.head_from_rd ? rd_data_ff : head_val_ff;
      head_rep   = (fill_ff == '0) ? '0 : head_now;
      popped_rep = pend_ff.pop_from_rd ? rd_data_ff : pend_ff.popped;
      cnt_ext    = {4'b0, fill_ff};
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, head_rep, cnt_ext[3:0], popped_rep, pend_ff.status};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_val_ff <= head_val_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_FULL)
      else $error("Fill count exceeds the deque depth.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ok |=> state_ff == cdq_pkg::S_BUSY)
      else $error("Accepted transaction did not start processing.");

   a_busy_result: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff && state_ff == cdq_pkg::S_IDLE)
      else $error("Finished transaction did not reach the result register.");

   a_tail_track: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> head_ff == tail_ff)
      else $error("Head and tail differ on an empty deque.");

endmodule

// File: test/circular_deque_checker.sv
// Checker for the circular deque: watches both stream channels, predicts every result
// from its own copy of the ring, indices and count, and compares. Depends on cdq_pkg.
`timescale 1ns / 1ps

module circular_deque_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // Fields from bit 0: func[1:0], push_value[33:2], zero pad[39:34].
   input  logic [cdq_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: status[1:0], popped_value[33:2], count[37:34],
   // head_value[69:38], zero pad[71:70].
   input  logic [cdq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned                    fail_count,
   output int unsigned                    outstanding
);

   localparam int RING_SIZE = 8;

   typedef struct packed {
      cdq_pkg::status_type status;
      logic [31:0]         popped;
      logic [3:0]          count;
      logic [31:0]         head;
   } deque_rsp_type;

   logic [31:0]    ring_words [RING_SIZE];
   logic [2:0]     front_ptr;
   logic [2:0]     back_ptr;
   logic [3:0]     elem_count;
   deque_rsp_type  expected_rsps [$];
   int unsigned    fail_total = 0;

   function automatic deque_rsp_type apply_deque_op(input cdq_pkg::op_type op,
                                                    input logic [31:0] word);
      deque_rsp_type r;
      r.status = cdq_pkg::ST_DONE;
      r.popped = '0;
      case (op)
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
            if (elem_count == RING_SIZE) begin
               r.status = cdq_pkg::ST_FULL;
            end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
               front_ptr = front_ptr - 3'd1;
               ring_words[front_ptr] = word;
               elem_count = elem_count + 4'd1;
            end else begin
               ring_words[back_ptr] = word;
               back_ptr = back_ptr + 3'd1;
               elem_count = elem_count + 4'd1;
            end
         end
         default: begin
            if (elem_count == 0) begin
               r.status = cdq_pkg::ST_EMPTY;
            end else if (op == cdq_pkg::OP_POP_FRONT) begin
               r.popped = ring_words[front_ptr];
               front_ptr = front_ptr + 3'd1;
               elem_count = elem_count - 4'd1;
            end else begin
               back_ptr = back_ptr - 3'd1;
               r.popped = ring_words[back_ptr];
               elem_count = elem_count - 4'd1;
            end
         end
      endcase
      r.count = elem_count;
      r.head  = (elem_count != 0) ? ring_words[front_ptr] : '0;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      deque_rsp_type want;
      deque_rsp_type got;
      if (reset) begin
         for (int i = 0; i < RING_SIZE; i++) ring_words[i] = '0;
         front_ptr  = '0;
         back_ptr   = '0;
         elem_count = '0;
         expected_rsps.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = cdq_pkg::status_type'(rsp_tdata[1:0]);
            got.popped = rsp_tdata[33:2];
            got.count  = rsp_tdata[37:34];
            got.head   = rsp_tdata[69:38];
            if (expected_rsps.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display({"%0t: unexpected result transaction: ",
                            "status %0d popped %h count %0d head %h"},
                           $realtime, got.status, got.popped, got.count, got.head);
            end else begin
               want = expected_rsps[0];
               expected_rsps.delete(0);
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"%0t: mismatch: status %0d/%0d popped %h/%h ",
                               "count %0d/%0d head %h/%h"},
                              $realtime, want.status, got.status, want.popped,
                              got.popped, want.count, got.count, want.head, got.head);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_rsps = {expected_rsps,
                             apply_deque_op(cdq_pkg::op_type'(req_tdata[1:0]),
                                            req_tdata[33:2])};
      end
      fail_count  <= fail_total;
      outstanding <= $unsigned(expected_rsps.size());
   end

endmodule

// File: test/circular_deque_test.sv
// Top of the circular deque testbench: clock, reset, request and response stimulus
// and the final verdict. Depends on cdq_pkg, circular_deque and circular_deque_checker.
`timescale 1ns / 1ps

module circular_deque_test;

   localparam int RANDOM_ITEMS = 650;
   localparam int QUIET_ITEMS  = 100;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 10;
   localparam int CYCLE_LIMIT  = 200000;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [cdq_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [cdq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           quiet      = 1'b0;
   int unsigned                    fail_count;
   int unsigned                    outstanding;

   always #5 clock = ~clock;

   circular_deque #(.DEPTH(8)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   circular_deque_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Called at a rising edge; returns where the transaction is taken, or after a random idle gap that follows it.
   task automatic send_item(input cdq_pkg::op_type op, input logic [31:0] word);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, word, op};
      do @(posedge clock); while (!req_tready);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : rsp_side
      int unsigned left;
      int unsigned taken;
      bit          ready_phase;
      bit          held;
      left        = 0;
      taken       = 0;
      ready_phase = 1'b0;
      held        = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (!held && taken >= 120) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            if (left == 0) begin
               ready_phase = ($urandom_range(0, 2) != 0);
               left = $urandom_range(1, 16);
            end
            left--;
            rsp_tready <= ready_phase;
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned     sent;
      int unsigned     seg_left;
      int unsigned     push_pct;
      cdq_pkg::op_type op;
      sent     = 0;
      seg_left = 0;
      push_pct = 50;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pops on an empty deque, then the last element leaving from either end.
      send_item(cdq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
      send_item(cdq_pkg::OP_POP_BACK, 32'h1234_5678);
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      send_item(cdq_pkg::OP_POP_BACK, 32'h0000_0000);
      send_item(cdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
      send_item(cdq_pkg::OP_POP_FRONT, 32'h0000_0000);
      // Fill to capacity from both ends, then push into the full deque.
      send_item(cdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_item(cdq_pkg::OP_PUSH_BACK, 32'h5555_5555);
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
      send_item(cdq_pkg::OP_PUSH_BACK, pick_word());
      send_item(cdq_pkg::OP_PUSH_FRONT, pick_word());
      send_item(cdq_pkg::OP_PUSH_BACK, 32'h8000_0000);
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
      send_item(cdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
      // Empty it again from alternating ends, then pop once more.
      for (int i = 0; i < 8; i++)
         send_item((i % 2 == 0) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK,
                   pick_word());
      send_item(cdq_pkg::OP_POP_BACK, 32'h0000_0000);
      drain_results();

      while (sent < RANDOM_ITEMS) begin
         if (seg_left == 0) begin
            if (sent != 0 && !quiet && $urandom_range(0, 3) == 0) drain_results();
            seg_left = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
               0:       push_pct = 25;
               1:       push_pct = 50;
               default: push_pct = 80;
            endcase
         end
         if (sent == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
         if ($urandom_range(1, 100) <= push_pct)
            op = cdq_pkg::op_type'(2'($urandom_range(0, 1)));
         else
            op = cdq_pkg::op_type'(2'($urandom_range(2, 3)));
         send_item(op, pick_word());
         seg_left--;
         sent++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
